// ===== src/golomb_bit_serial_decoder_defines.svh =====
// ----------------------------------------------------------------------------
// golomb_bit_serial_decoder_defines.svh
// assertion macros shared by the decoder's checker
// ----------------------------------------------------------------------------
`ifndef GOLOMB_BIT_SERIAL_DECODER_DEFINES_SVH
`define GOLOMB_BIT_SERIAL_DECODER_DEFINES_SVH

// same-cycle implication
`define GBSD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define GBSD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/gbsd_pkg.sv =====
// ----------------------------------------------------------------------------
// gbsd_pkg
// shared constants and types of the bit-serial golomb decoder
// ----------------------------------------------------------------------------
package gbsd_pkg;

   localparam int DIVISOR_WIDTH_DEF    = 16;
   localparam int VALUE_WIDTH_DEF      = 32;
   localparam int QUOTIENT_WIDTH_DEF   = 20;
   localparam int QUOTIENT_LIMIT_RESET = 100000;
   localparam int DIVISOR_RESET        = 1;

   localparam int PADDR_WIDTH = 4;
   localparam int PDATA_WIDTH = 32;

   localparam logic [1:0] REG_DIVISOR        = 2'd0;
   localparam logic [1:0] REG_SIGN_MODE      = 2'd1;
   localparam logic [1:0] REG_QUOTIENT_LIMIT = 2'd2;

   typedef enum logic [3:0] {
      PH_START  = 4'b0001,
      PH_UNARY  = 4'b0010,
      PH_PREFIX = 4'b0100,
      PH_EXTRA  = 4'b1000
   } phase_type;

endpackage

// ===== src/gbsd_req_if.sv =====
// ----------------------------------------------------------------------------
// gbsd_req_if
// code bit channel: one stream bit or a stream end marker per transaction
// ----------------------------------------------------------------------------
interface gbsd_req_if;

   logic valid;
   logic ready;
   logic code_bit;
   logic stream_end;

   modport source (output valid, output code_bit, output stream_end, input ready);
   modport sink   (input valid, input code_bit, input stream_end, output ready);

endinterface

// ===== src/gbsd_rsp_if.sv =====
// ----------------------------------------------------------------------------
// gbsd_rsp_if
// decoded value channel: one signed value per transaction
// ----------------------------------------------------------------------------
interface gbsd_rsp_if #(
   parameter int VALUE_WIDTH = gbsd_pkg::VALUE_WIDTH_DEF
);

   logic                          valid;
   logic                          ready;
   logic signed [VALUE_WIDTH-1:0] decoded_value;
   logic                          quotient_error;

   modport source (output valid, output decoded_value, output quotient_error, input ready);
   modport sink   (input valid, input decoded_value, input quotient_error, output ready);

endinterface

// ===== src/gbsd_csr.sv =====
// ----------------------------------------------------------------------------
// gbsd_csr
// apb register file: divisor, sign mode, quotient limit and derived code sizes
// ----------------------------------------------------------------------------
module gbsd_csr #(
   parameter int DIVISOR_WIDTH  = gbsd_pkg::DIVISOR_WIDTH_DEF,
   parameter int QUOTIENT_WIDTH = gbsd_pkg::QUOTIENT_WIDTH_DEF,
   parameter int CW_WIDTH       = $clog2(DIVISOR_WIDTH + 1)
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [gbsd_pkg::PADDR_WIDTH-1:0] paddr,
   input  logic [gbsd_pkg::PDATA_WIDTH-1:0] pwdata,
   output logic [gbsd_pkg::PDATA_WIDTH-1:0] prdata,
   output logic                            pready,
   output logic [DIVISOR_WIDTH-1:0]        divisor,
   output logic                            sign_mode,
   output logic [QUOTIENT_WIDTH-1:0]       quotient_limit,
   output logic [CW_WIDTH-1:0]             code_width,
   output logic [DIVISOR_WIDTH-1:0]        short_code_count,
   output logic                            restart
);
   import gbsd_pkg::*;

   logic [DIVISOR_WIDTH-1:0]  divisor_ff,    divisor_in;
   logic                      sign_mode_ff,  sign_mode_in;
   logic [QUOTIENT_WIDTH-1:0] qlimit_ff,     qlimit_in;
   logic [CW_WIDTH-1:0]       cw_ff,         cw_in;
   logic [DIVISOR_WIDTH-1:0]  scc_ff,        scc_in;
   logic                      wr_en;
   logic [1:0]                wr_idx;
   logic [DIVISOR_WIDTH-1:0]  wr_divisor;
   logic [DIVISOR_WIDTH:0]    pow_cw;

   function automatic logic [CW_WIDTH-1:0] ceil_log2(input logic [DIVISOR_WIDTH-1:0] d);
      logic [DIVISOR_WIDTH-1:0] t;
      logic [CW_WIDTH-1:0]      w;
      t = d - DIVISOR_WIDTH'(1);
      w = '0;
      for (int i = 0; i < DIVISOR_WIDTH; i++) begin
         if (t[i]) begin
            w = CW_WIDTH'(i + 1);
         end
      end
      return w;
   endfunction

   assign wr_en      = psel && penable && pwrite && pready;
   assign wr_idx     = paddr[PADDR_WIDTH-1:2];
   assign wr_divisor = (pwdata[DIVISOR_WIDTH-1:0] == '0) ? DIVISOR_WIDTH'(1)
                                                         : pwdata[DIVISOR_WIDTH-1:0];
   assign pow_cw     = (DIVISOR_WIDTH+1)'(1) << ceil_log2(wr_divisor);

   always_comb begin
      divisor_in   = divisor_ff;
      sign_mode_in = sign_mode_ff;
      qlimit_in    = qlimit_ff;
      cw_in        = cw_ff;
      scc_in       = scc_ff;
      restart      = 1'b0;
      if (wr_en) begin
         case (wr_idx)
            REG_DIVISOR: begin
               divisor_in = wr_divisor;
               cw_in      = ceil_log2(wr_divisor);
               scc_in     = DIVISOR_WIDTH'(pow_cw - {1'b0, wr_divisor});
               restart    = 1'b1;
            end
            REG_SIGN_MODE: begin
               sign_mode_in = pwdata[0];
               restart      = 1'b1;
            end
            REG_QUOTIENT_LIMIT: begin
               qlimit_in = pwdata[QUOTIENT_WIDTH-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         divisor_ff   <= DIVISOR_WIDTH'(DIVISOR_RESET);
         sign_mode_ff <= 1'b0;
         qlimit_ff    <= QUOTIENT_WIDTH'(QUOTIENT_LIMIT_RESET);
         cw_ff        <= '0;
         scc_ff       <= '0;
      end else begin
         divisor_ff   <= divisor_in;
         sign_mode_ff <= sign_mode_in;
         qlimit_ff    <= qlimit_in;
         cw_ff        <= cw_in;
         scc_ff       <= scc_in;
      end
   end

   always_comb begin
      case (wr_idx)
         REG_DIVISOR:        prdata = PDATA_WIDTH'(divisor_ff);
         REG_SIGN_MODE:      prdata = PDATA_WIDTH'(sign_mode_ff);
         REG_QUOTIENT_LIMIT: prdata = PDATA_WIDTH'(qlimit_ff);
         default:            prdata = '0;
      endcase
   end

   assign pready           = 1'b1;
   assign divisor          = divisor_ff;
   assign sign_mode        = sign_mode_ff;
   assign quotient_limit   = qlimit_ff;
   assign code_width       = cw_ff;
   assign short_code_count = scc_ff;

endmodule

// ===== src/golomb_bit_serial_decoder.sv =====
// ----------------------------------------------------------------------------
// golomb_bit_serial_decoder
// golomb decoder with unary quotient and truncated binary remainder
// ----------------------------------------------------------------------------
// Takes one code bit per clock and sustains one bit per cycle unless rsp stalls
// with the input register full. A bit sits in an input register, then the
// codeword state update (one saturating add of the divisor or remainder, then
// sign or zigzag mapping) writes the result register, so a completed codeword
// reaches rsp from its last bit through the input register and the result
// register. The result register lets the next bit in while a value waits; req
// stalls only when rsp holds a value that is not taken and the input register
// is full. Registers sit on an APB port at 0x0 divisor, 0x4 sign mode, 0x8
// quotient limit; writing divisor or sign mode drops any partial codeword.
module golomb_bit_serial_decoder #(
   parameter int DIVISOR_WIDTH  = gbsd_pkg::DIVISOR_WIDTH_DEF,
   parameter int VALUE_WIDTH    = gbsd_pkg::VALUE_WIDTH_DEF,
   parameter int QUOTIENT_WIDTH = gbsd_pkg::QUOTIENT_WIDTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   gbsd_req_if.sink                         req,
   gbsd_rsp_if.source                       rsp,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [gbsd_pkg::PADDR_WIDTH-1:0] paddr,
   input  logic [gbsd_pkg::PDATA_WIDTH-1:0] pwdata,
   output logic [gbsd_pkg::PDATA_WIDTH-1:0] prdata,
   output logic                             pready
);
   import gbsd_pkg::*;

   localparam int CW_WIDTH = $clog2(DIVISOR_WIDTH + 1);
   localparam int REM_W    = DIVISOR_WIDTH + 1;
   localparam int SUM_W    = ((VALUE_WIDTH - 1 > REM_W) ? VALUE_WIDTH - 1 : REM_W) + 1;
   localparam logic [VALUE_WIDTH-2:0] MAG_MAX = '1;

   logic [DIVISOR_WIDTH-1:0]  divisor;
   logic                      sign_mode;
   logic [QUOTIENT_WIDTH-1:0] quotient_limit;
   logic [CW_WIDTH-1:0]       code_width;
   logic [DIVISOR_WIDTH-1:0]  scc;
   logic                      cfg_restart;

   logic in_valid_ff, in_valid_in;
   logic in_bit_ff, in_end_ff;
   logic advance, fire;

   phase_type                 phase_ff,  phase_in;
   logic                      neg_ff,    neg_in;
   logic [QUOTIENT_WIDTH-1:0] qcount_ff, qcount_in;
   logic [VALUE_WIDTH-2:0]    acc_ff,    acc_in;
   logic [DIVISOR_WIDTH-1:0]  rshift_ff, rshift_in;
   logic [CW_WIDTH-1:0]       bleft_ff,  bleft_in;

   logic                          out_valid_ff, out_valid_in;
   logic signed [VALUE_WIDTH-1:0] value_ff;
   logic                          error_ff;

   logic [DIVISOR_WIDTH-1:0] rs_next;
   logic [REM_W-1:0]         rs_full;
   logic [REM_W-1:0]         extra_rem;
   logic [CW_WIDTH-1:0]      bl_dec;
   logic [REM_W-1:0]         addend;
   logic [SUM_W-1:0]         sum;
   logic [VALUE_WIDTH-2:0]   mag;
   logic [VALUE_WIDTH-1:0]   mag_ext;
   logic [VALUE_WIDTH-1:0]   half_up;
   logic [VALUE_WIDTH-1:0]   mapped;
   logic                     emit, emit_err;

   gbsd_csr #(
      .DIVISOR_WIDTH  (DIVISOR_WIDTH),
      .QUOTIENT_WIDTH (QUOTIENT_WIDTH),
      .CW_WIDTH       (CW_WIDTH)
   ) u_csr (
      .clock            (clock),
      .reset            (reset),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready),
      .divisor          (divisor),
      .sign_mode        (sign_mode),
      .quotient_limit   (quotient_limit),
      .code_width       (code_width),
      .short_code_count (scc),
      .restart          (cfg_restart)
   );

   // handshake
   assign advance     = !out_valid_ff || rsp.ready;
   assign fire        = in_valid_ff && advance;
   assign req.ready   = !in_valid_ff || advance;
   assign in_valid_in = req.ready ? req.valid : in_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         in_bit_ff <= req.code_bit;
         in_end_ff <= req.stream_end;
      end
   end

   // datapath
   assign rs_next   = DIVISOR_WIDTH'({rshift_ff, in_bit_ff});
   assign rs_full   = {rshift_ff, in_bit_ff};
   assign extra_rem = (rs_full >= {1'b0, scc}) ? rs_full - {1'b0, scc} : '0;
   assign bl_dec    = (bleft_ff == '0) ? '0 : bleft_ff - CW_WIDTH'(1);

   always_comb begin
      case (phase_ff)
         PH_PREFIX: addend = {1'b0, rs_next};
         PH_EXTRA:  addend = extra_rem;
         default:   addend = in_bit_ff ? '0 : {1'b0, divisor};
      endcase
   end

   assign sum     = SUM_W'(acc_ff) + SUM_W'(addend);
   assign mag     = (sum > SUM_W'(MAG_MAX)) ? MAG_MAX : sum[VALUE_WIDTH-2:0];
   assign mag_ext = {1'b0, mag};
   assign half_up = (mag_ext + VALUE_WIDTH'(1)) >> 1;

   always_comb begin
      if (sign_mode) begin
         mapped = neg_ff ? -mag_ext : mag_ext;
      end else if (mag[0]) begin
         mapped = -half_up;
      end else begin
         mapped = mag_ext >> 1;
      end
   end

   // codeword state
   always_comb begin
      phase_in  = phase_ff;
      neg_in    = neg_ff;
      qcount_in = qcount_ff;
      acc_in    = acc_ff;
      rshift_in = rshift_ff;
      bleft_in  = bleft_ff;
      emit      = 1'b0;
      emit_err  = 1'b0;
      if (fire && !in_end_ff) begin
         case (phase_ff)
            PH_START, PH_UNARY: begin
               if (phase_ff == PH_START && sign_mode) begin
                  neg_in   = in_bit_ff;
                  phase_in = PH_UNARY;
               end else if (!in_bit_ff) begin
                  if (qcount_ff >= quotient_limit) begin
                     emit     = 1'b1;
                     emit_err = 1'b1;
                  end else begin
                     qcount_in = qcount_ff + QUOTIENT_WIDTH'(1);
                     acc_in    = mag;
                     phase_in  = PH_UNARY;
                  end
               end else if (code_width == '0) begin
                  emit = 1'b1;
               end else begin
                  bleft_in  = (scc == '0) ? code_width : code_width - CW_WIDTH'(1);
                  rshift_in = '0;
                  phase_in  = PH_PREFIX;
               end
            end
            PH_PREFIX: begin
               rshift_in = rs_next;
               bleft_in  = bl_dec;
               if (bl_dec == '0) begin
                  if (scc == '0 || rs_next < scc) begin
                     emit = 1'b1;
                  end else begin
                     phase_in = PH_EXTRA;
                  end
               end
            end
            PH_EXTRA: begin
               emit = 1'b1;
            end
            default: begin
               phase_in = PH_START;
            end
         endcase
      end
      if (cfg_restart || (fire && in_end_ff) || emit) begin
         phase_in  = PH_START;
         neg_in    = 1'b0;
         qcount_in = '0;
         acc_in    = '0;
         rshift_in = '0;
         bleft_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_START;
         neg_ff    <= 1'b0;
         qcount_ff <= '0;
         acc_ff    <= '0;
         rshift_ff <= '0;
         bleft_ff  <= '0;
      end else begin
         phase_ff  <= phase_in;
         neg_ff    <= neg_in;
         qcount_ff <= qcount_in;
         acc_ff    <= acc_in;
         rshift_ff <= rshift_in;
         bleft_ff  <= bleft_in;
      end
   end

   // result register
   assign out_valid_in = (fire && emit) ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && emit) begin
         value_ff <= emit_err ? '0 : mapped;
         error_ff <= emit_err;
      end
   end

   assign rsp.valid          = out_valid_ff;
   assign rsp.decoded_value  = value_ff;
   assign rsp.quotient_error = error_ff;

endmodule

// ===== src/gbsd_checker.sv =====
// ----------------------------------------------------------------------------
// gbsd_checker
// port-level checks of the golomb decoder, bound to the top level
// ----------------------------------------------------------------------------
`include "golomb_bit_serial_decoder_defines.svh"

module gbsd_checker #(
   parameter int VALUE_WIDTH = gbsd_pkg::VALUE_WIDTH_DEF
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic signed [VALUE_WIDTH-1:0] rsp_decoded_value,
   input logic                          rsp_quotient_error
);

   // an error transaction always carries a zero value
   `GBSD_ASSERT_NOW(a_error_value_zero, clock, reset, rsp_valid && rsp_quotient_error, rsp_decoded_value == '0, "quotient error with nonzero value")

   // input backpressure only while a result is stuck
   `GBSD_ASSERT_NOW(a_req_stall_cause, clock, reset, !req_ready, rsp_valid && !rsp_ready, "req stalled without rsp backpressure")

   // a stalled result is held
   `GBSD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_decoded_value) && $stable(rsp_quotient_error), "rsp changed while stalled")

   // input open whenever the result stage can move
   `GBSD_ASSERT_NOW(a_req_no_bubble, clock, reset, !rsp_valid || rsp_ready, req_ready, "req stalled while the result stage can move")

endmodule

bind golomb_bit_serial_decoder gbsd_checker #(
   .VALUE_WIDTH (VALUE_WIDTH)
) u_gbsd_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req.valid),
   .req_ready          (req.ready),
   .rsp_valid          (rsp.valid),
   .rsp_ready          (rsp.ready),
   .rsp_decoded_value  (rsp.decoded_value),
   .rsp_quotient_error (rsp.quotient_error)
);

// ===== sim/golomb_bit_serial_decoder_tb.sv =====
// ----------------------------------------------------------------------------
// golomb_bit_serial_decoder_tb
// self-checking bench for the bit-serial golomb decoder: a directed table of
// code bits and register writes, then random codewords, noise and cut-off
// codewords over several divisor, sign mode and quotient limit settings.
// every decoded value is checked against a bit-accurate decoder model kept
// in the bench, or against the table value for checked table rows, with
// bursty input and a stalling result sink.
module golomb_bit_serial_decoder_tb;

   timeunit 1ns;
   timeprecision 1ps;

   import gbsd_pkg::*;

   localparam int          RESET_CYCLES  = 10;
   localparam int          DRAIN_CYCLES  = 6;
   localparam int          TAIL_CYCLES   = 20;
   localparam int          CYCLE_LIMIT   = 100000;
   localparam int          RANDOM_PHASES = 10;
   localparam int          PHASE_ITEMS   = 60;
   localparam logic [31:0] MAG_MAX       = 32'h7FFF_FFFF;
   localparam logic [15:0] DIVISOR_MAX   = 16'hFFFF;
   localparam logic [19:0] LIMIT_MAX     = 20'hF_FFFF;

   localparam int unsigned DIVISOR_PICKS [12] = '{1, 2, 3, 4, 5, 7, 100, 255, 256, 257,
                                                  32768, 65535};

   typedef struct packed {
      logic [31:0] value;
      logic        error;
   } decoded_result_type;

   typedef enum logic {ROW_BIT, ROW_REG} row_kind_type;

   typedef struct {
      row_kind_type       kind;
      logic               code_bit;
      logic               stream_end;
      logic [1:0]         reg_index;
      logic [31:0]        reg_value;
      logic               checked;
      decoded_result_type result;
   } stimulus_row_type;

   typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_PERIODIC, RX_LONG} stall_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [PADDR_WIDTH-1:0] paddr;
   logic [PDATA_WIDTH-1:0] pwdata;
   logic [PDATA_WIDTH-1:0] prdata;
   logic        pready;

   gbsd_req_if req ();
   gbsd_rsp_if rsp ();

   golomb_bit_serial_decoder u_top (
      .clock   (clock),
      .reset   (reset),
      .req     (req),
      .rsp     (rsp),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // decoder model state
   logic [15:0] cfg_divisor;
   logic        cfg_sign_mode;
   logic [19:0] cfg_quotient_limit;
   phase_type   dec_phase;
   logic        dec_negative;
   logic [19:0] dec_quotient;
   logic [31:0] dec_magnitude;
   logic [15:0] dec_remainder;
   logic [4:0]  dec_bits_left;
   logic [4:0]  code_width;
   logic [15:0] short_codes;

   decoded_result_type pending_values [$];
   stimulus_row_type   stimulus_rows [$];
   int unsigned        fail_count  = 0;
   int unsigned        cycle_count = 0;
   int unsigned        item_count  = 0;
   int unsigned        burst_left  = 0;

   function automatic logic [31:0] saturate_add(logic [31:0] a, logic [31:0] b);
      logic [32:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return (sum > {1'b0, MAG_MAX}) ? MAG_MAX : sum[31:0];
   endfunction

   task automatic derive_code_widths();
      logic [15:0] span;
      logic [16:0] full_range;
      span = cfg_divisor - 16'd1;
      code_width = '0;
      while (span != 0) begin
         code_width++;
         span = span >> 1;
      end
      full_range = (17'd1 << code_width) - {1'b0, cfg_divisor};
      short_codes = full_range[15:0];
   endtask

   task automatic restart_decoder();
      dec_phase     = PH_START;
      dec_negative  = 1'b0;
      dec_quotient  = '0;
      dec_magnitude = '0;
      dec_remainder = '0;
      dec_bits_left = '0;
   endtask

   task automatic close_codeword(input logic [31:0] rem, output decoded_result_type res);
      logic [31:0] mag;
      logic [32:0] bumped;
      mag = saturate_add(dec_magnitude, rem);
      bumped = {1'b0, mag} + 33'd1;
      if (cfg_sign_mode) begin
         res.value = dec_negative ? (32'd0 - mag) : mag;
      end else if (mag[0]) begin
         res.value = 32'd0 - bumped[32:1];
      end else begin
         res.value = mag >> 1;
      end
      res.error = 1'b0;
      restart_decoder();
   endtask

   task automatic unary_step(input logic cb, output logic produced,
                             output decoded_result_type res);
      produced = 1'b0;
      res = '0;
      if (!cb) begin
         if (dec_quotient >= cfg_quotient_limit) begin
            res.error = 1'b1;
            produced = 1'b1;
            restart_decoder();
         end else begin
            dec_quotient++;
            dec_magnitude = saturate_add(dec_magnitude, {16'd0, cfg_divisor});
            dec_phase = PH_UNARY;
         end
      end else if (code_width == 0) begin
         close_codeword(32'd0, res);
         produced = 1'b1;
      end else begin
         dec_bits_left = (short_codes == 0) ? code_width : code_width - 5'd1;
         dec_remainder = '0;
         dec_phase = PH_PREFIX;
      end
   endtask

   task automatic golomb_decode_bit(input logic cb, input logic se,
                                    output logic produced, output decoded_result_type res);
      logic [31:0] full;
      produced = 1'b0;
      res = '0;
      if (se) begin
         restart_decoder();
      end else begin
         case (dec_phase)
            PH_START: begin
               if (cfg_sign_mode) begin
                  dec_negative = cb;
                  dec_phase = PH_UNARY;
               end else begin
                  unary_step(cb, produced, res);
               end
            end
            PH_UNARY: begin
               unary_step(cb, produced, res);
            end
            PH_PREFIX: begin
               dec_remainder = {dec_remainder[14:0], cb};
               if (dec_bits_left != 0) dec_bits_left--;
               if (dec_bits_left == 0) begin
                  if (short_codes == 0 || dec_remainder < short_codes) begin
                     close_codeword({16'd0, dec_remainder}, res);
                     produced = 1'b1;
                  end else begin
                     dec_phase = PH_EXTRA;
                  end
               end
            end
            default: begin
               full = {15'd0, dec_remainder, cb};
               close_codeword((full >= {16'd0, short_codes}) ? full - {16'd0, short_codes} : 32'd0,
                              res);
               produced = 1'b1;
            end
         endcase
      end
   endtask

   task automatic send_item(input logic cb, input logic se, input logic checked,
                            input decoded_result_type typed);
      logic               produced;
      decoded_result_type res;
      int unsigned        gap;
      @(negedge clock);
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         burst_left = $urandom_range(1, 24);
         if (gap > 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req.valid      <= 1'b1;
      req.code_bit   <= cb;
      req.stream_end <= se;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      golomb_decode_bit(cb, se, produced, res);
      if (checked) pending_values.push_back(typed);
      else if (produced) pending_values.push_back(res);
      item_count++;
   endtask

   task automatic program_register(input logic [1:0] idx, input logic [31:0] value);
      @(negedge clock);
      req.valid <= 1'b0;
      while (pending_values.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      case (idx)
         REG_DIVISOR: begin
            cfg_divisor = (value[15:0] == 0) ? 16'd1 : value[15:0];
            derive_code_widths();
            restart_decoder();
         end
         REG_SIGN_MODE: begin
            cfg_sign_mode = value[0];
            restart_decoder();
         end
         REG_QUOTIENT_LIMIT: cfg_quotient_limit = value[19:0];
         default: ;
      endcase
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic send_codeword(input int unsigned quotient, input int unsigned rem,
                                input logic negative, input logic broken);
      logic               bits [$];
      int unsigned        width;
      int unsigned        code;
      int unsigned        cut;
      decoded_result_type none;
      none = '0;
      if (cfg_sign_mode) bits.push_back(negative);
      repeat (quotient) bits.push_back(1'b0);
      bits.push_back(1'b1);
      if (code_width != 0) begin
         if (short_codes == 0) begin
            width = code_width;
            code  = rem;
         end else if (rem < short_codes) begin
            width = code_width - 1;
            code  = rem;
         end else begin
            width = code_width;
            code  = rem + short_codes;
         end
         for (int i = int'(width) - 1; i >= 0; i--) bits.push_back(code[i]);
      end
      cut = broken ? $urandom_range(0, bits.size() - 1) : bits.size();
      for (int i = 0; i < int'(cut); i++) send_item(bits[i], 1'b0, 1'b0, none);
      if (broken) send_item(1'($urandom_range(0, 1)), 1'b1, 1'b0, none);
   endtask

   function automatic logic [31:0] with_junk(logic [31:0] value, int width);
      logic [31:0] mask;
      mask = (width >= 32) ? 32'hFFFF_FFFF : ((32'd1 << width) - 32'd1);
      if ($urandom_range(0, 3) == 0) return (value & mask) | ($urandom & ~mask);
      return value & mask;
   endfunction

   function automatic stimulus_row_type bit_row(logic cb, logic se);
      stimulus_row_type row;
      row = '{ROW_BIT, cb, se, REG_DIVISOR, 32'd0, 1'b0, '0};
      return row;
   endfunction

   function automatic stimulus_row_type checked_row(logic cb, logic [31:0] value, logic err);
      stimulus_row_type row;
      row = '{ROW_BIT, cb, 1'b0, REG_DIVISOR, 32'd0, 1'b1, '{value, err}};
      return row;
   endfunction

   function automatic stimulus_row_type reg_row(logic [1:0] idx, logic [31:0] value);
      stimulus_row_type row;
      row = '{ROW_REG, 1'b0, 1'b0, idx, value, 1'b0, '0};
      return row;
   endfunction

   // result sink with its own stall pattern
   stall_mode_type rx_mode      = RX_OPEN;
   int unsigned    rx_mode_left = 0;
   int unsigned    rx_stall     = 0;
   int unsigned    rx_tick      = 0;

   always @(negedge clock) begin
      logic take;
      if (rx_mode_left == 0) begin
         rx_mode = stall_mode_type'($urandom_range(0, 3));
         rx_mode_left = $urandom_range(20, 200);
      end
      rx_mode_left--;
      rx_tick++;
      case (rx_mode)
         RX_OPEN:     take = 1'b1;
         RX_COIN:     take = 1'($urandom_range(0, 1));
         RX_PERIODIC: take = (rx_tick % 3) != 0;
         default: begin
            if (rx_stall != 0) begin
               rx_stall--;
               take = 1'b0;
            end else begin
               take = 1'b1;
               if ($urandom_range(0, 7) == 0) rx_stall = $urandom_range(1, 12);
            end
         end
      endcase
      rsp.ready <= take;
   end

   always @(posedge clock) begin
      decoded_result_type want;
      cycle_count++;
      if (!reset && rsp.valid && rsp.ready) begin
         if (pending_values.size() == 0) begin
            fail_count++;
            $display("%0t: unexpected transaction: expected none, actual value %0d error %0b",
                     $time, rsp.decoded_value, rsp.quotient_error);
         end else begin
            want = pending_values.pop_front();
            if (rsp.decoded_value !== want.value) begin
               fail_count++;
               $display("%0t: decoded_value mismatch: expected %0d, actual %0d",
                        $time, $signed(want.value), rsp.decoded_value);
            end
            if (rsp.quotient_error !== want.error) begin
               fail_count++;
               $display("%0t: quotient_error mismatch: expected %0b, actual %0b",
                        $time, want.error, rsp.quotient_error);
            end
         end
      end
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      logic [15:0]        div;
      logic               sgn;
      logic [19:0]        lim;
      int unsigned        start;
      int unsigned        kind;
      int unsigned        q;
      int unsigned        r;
      int unsigned        cap;
      decoded_result_type none;

      none = '0;
      req.valid      = 1'b0;
      req.code_bit   = 1'b0;
      req.stream_end = 1'b0;
      rsp.ready      = 1'b0;
      psel           = 1'b0;
      penable        = 1'b0;
      pwrite         = 1'b0;
      paddr          = '0;
      pwdata         = '0;

      cfg_divisor        = 16'(DIVISOR_RESET);
      cfg_sign_mode      = 1'b0;
      cfg_quotient_limit = 20'(QUOTIENT_LIMIT_RESET);
      derive_code_widths();
      restart_decoder();

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // after reset: divisor one, zigzag, default limit
      stimulus_rows.push_back(checked_row(1'b1, 32'd0, 1'b0));
      stimulus_rows.push_back(bit_row(1'b0, 1'b0));
      stimulus_rows.push_back(checked_row(1'b1, 32'hFFFF_FFFF, 1'b0));
      stimulus_rows.push_back(bit_row(1'b0, 1'b0));
      stimulus_rows.push_back(bit_row(1'b0, 1'b0));
      stimulus_rows.push_back(bit_row(1'b1, 1'b0));
      // stream end drops the partial codeword
      stimulus_rows.push_back(bit_row(1'b0, 1'b0));
      stimulus_rows.push_back(bit_row(1'b1, 1'b1));
      stimulus_rows.push_back(bit_row(1'b0, 1'b1));
      stimulus_rows.push_back(checked_row(1'b1, 32'd0, 1'b0));
      // zero limit: first zero is an error
      stimulus_rows.push_back(reg_row(REG_QUOTIENT_LIMIT, 32'd0));
      stimulus_rows.push_back(checked_row(1'b0, 32'd0, 1'b1));
      stimulus_rows.push_back(checked_row(1'b1, 32'd0, 1'b0));
      // sign and magnitude, truncated binary with the extra bit
      stimulus_rows.push_back(reg_row(REG_QUOTIENT_LIMIT, {12'd0, LIMIT_MAX}));
      stimulus_rows.push_back(reg_row(REG_SIGN_MODE, 32'd1));
      stimulus_rows.push_back(reg_row(REG_DIVISOR, 32'd5));
      stimulus_rows.push_back(bit_row(1'b1, 1'b0));
      stimulus_rows.push_back(bit_row(1'b1, 1'b0));
      stimulus_rows.push_back(bit_row(1'b1, 1'b0));
      stimulus_rows.push_back(bit_row(1'b1, 1'b0));
      stimulus_rows.push_back(bit_row(1'b1, 1'b0));
      stimulus_rows.push_back(bit_row(1'b0, 1'b0));
      stimulus_rows.push_back(bit_row(1'b0, 1'b0));
      stimulus_rows.push_back(bit_row(1'b1, 1'b0));
      stimulus_rows.push_back(bit_row(1'b0, 1'b0));
      stimulus_rows.push_back(bit_row(1'b0, 1'b0));
      // divisor zero is taken as one
      stimulus_rows.push_back(reg_row(REG_DIVISOR, 32'd0));
      stimulus_rows.push_back(bit_row(1'b1, 1'b0));
      stimulus_rows.push_back(checked_row(1'b1, 32'd0, 1'b0));
      stimulus_rows.push_back(bit_row(1'b0, 1'b0));
      stimulus_rows.push_back(bit_row(1'b0, 1'b0));
      stimulus_rows.push_back(checked_row(1'b1, 32'd1, 1'b0));

      foreach (stimulus_rows[i]) begin
         if (stimulus_rows[i].kind == ROW_REG) begin
            program_register(stimulus_rows[i].reg_index, stimulus_rows[i].reg_value);
         end else begin
            send_item(stimulus_rows[i].code_bit, stimulus_rows[i].stream_end,
                      stimulus_rows[i].checked, stimulus_rows[i].result);
         end
      end

      // random phases
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         case (ph)
            0:       div = 16'd1;
            1:       div = DIVISOR_MAX;
            2:       div = 16'd2;
            3:       div = 16'd3;
            default: div = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                                       : 16'(DIVISOR_PICKS[$urandom_range(0, 11)]);
         endcase
         sgn = (ph < 4) ? ph[0] : 1'($urandom_range(0, 1));
         case ($urandom_range(0, 4))
            0:       lim = 20'($urandom_range(0, 3));
            1:       lim = LIMIT_MAX;
            2:       lim = 20'(QUOTIENT_LIMIT_RESET);
            default: lim = 20'($urandom_range(1, 8));
         endcase
         program_register(REG_DIVISOR, with_junk({16'd0, div}, 16));
         program_register(REG_SIGN_MODE, with_junk({31'd0, sgn}, 1));
         program_register(REG_QUOTIENT_LIMIT, with_junk({12'd0, lim}, 20));
         start = item_count;
         while (item_count - start < PHASE_ITEMS) begin
            kind = $urandom_range(0, 9);
            cap  = (cfg_quotient_limit > 22) ? 24 : cfg_quotient_limit + 2;
            q    = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 3) : $urandom_range(0, cap);
            case ($urandom_range(0, 3))
               0:       r = 0;
               1:       r = cfg_divisor - 1;
               default: r = $urandom_range(0, cfg_divisor - 1);
            endcase
            if (kind < 7) begin
               send_codeword(q, r, 1'($urandom_range(0, 1)), 1'b0);
            end else if (kind < 9) begin
               repeat ($urandom_range(1, 6))
                  send_item(1'($urandom_range(0, 1)), $urandom_range(0, 4) == 0, 1'b0, none);
            end else begin
               send_codeword(q, r, 1'($urandom_range(0, 1)), 1'b1);
            end
         end
      end

      @(negedge clock);
      req.valid <= 1'b0;
      while (pending_values.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
